/* hdl/cfv_pkg.sv */
// Constants and types shared by the checkpoint frame validator.
package cfv_pkg;

    localparam int unsigned WORD_W      = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam logic [WORD_W-1:0] SUM_SEED   = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] SUM_MULT   = 32'd16777619;
    localparam logic [WORD_W-1:0] SUM_INC    = 32'd1;
    localparam logic [WORD_W-1:0] HDR_BYTES  = 32'd12;
    localparam logic [WORD_W-1:0] MIN_BYTES  = 32'd16;
    localparam logic [WORD_W-1:0] FOOTER_LEN = 32'd4;
    localparam logic [WORD_W-1:0] COUNT_MAX  = 32'hFFFF_FFFF;

    // Byte positions of the last byte of each header word
    localparam logic [WORD_W-1:0] MAGIC_END   = 32'd3;
    localparam logic [WORD_W-1:0] VERSION_END = 32'd7;
    localparam logic [WORD_W-1:0] LENGTH_END  = 32'd11;

    localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERSION = 1'd1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_BAD_VER   = 3'd3,
        ST_BAD_LEN   = 3'd4,
        ST_BAD_SUM   = 3'd5
    } status_t;

    // One checksum step: (sum + byte) * mult + 1, modulo 2^32
    function automatic logic [WORD_W-1:0] sum_step(
        input logic [WORD_W-1:0] sum,
        input logic [BYTE_W-1:0] b
    );
        logic [WORD_W-1:0] acc;
        logic [2*WORD_W-1:0] prod;
        acc  = sum + {{(WORD_W-BYTE_W){1'b0}}, b};
        prod = acc * SUM_MULT;
        return prod[WORD_W-1:0] + SUM_INC;
    endfunction

endpackage

/* hdl/checkpoint_frame_validator_unit.sv */
// Top level of the checkpoint frame validator: byte intake, frame checks and status output.
//
// Usage:
//   The input channel (in_valid, in_stall, data_byte, last_byte) carries one file byte per
//   item; last_byte marks the final byte of a file. The output channel (out_valid,
//   out_stall, status, body_length) carries one status item per file.
//   Configuration (cfg_wen, cfg_index, cfg_data) sets the expected magic (index 0) and
//   version (index 1) words; write them only while no file is in flight.
//   Throughput: one byte per cycle while in_stall is low. The byte stage updates the
//   header shifter, the checksum (one constant multiply-add) and the footer shifter in
//   the cycle it accepts a byte. On the last byte the frame totals move to a check stage
//   and the frame state clears, so the next file can start in the following cycle.
//   Output: the status item is formed from the check stage and held in the output register.
//   Stall: while the receiver stalls, the status waits in the output register; one
//   more finished frame may wait in the check stage, and in_stall rises only when
//   both are full.
//   Reset: clears the frame state, the configuration registers and both output stages.
module checkpoint_frame_validator_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [cfv_pkg::BYTE_W-1:0]    data_byte,
    input  logic                          last_byte,
    input  logic                          cfg_wen,
    input  logic [cfv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cfv_pkg::WORD_W-1:0]    cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [2:0]                    status,
    output logic [cfv_pkg::WORD_W-1:0]    body_length
);
    import cfv_pkg::*;

    // Configuration
    logic [WORD_W-1:0] magic_cfg_reg;
    logic [WORD_W-1:0] version_cfg_reg;

    // Frame state
    logic [WORD_W-1:0] count_reg,  count_next;
    logic [WORD_W-1:0] shift_reg,  shift_next;
    logic              magic_reg,  magic_next;
    logic              ver_reg,    ver_next;
    logic [WORD_W-1:0] decl_reg,   decl_next;
    logic [WORD_W-1:0] sum_reg,    sum_next;
    logic [WORD_W-1:0] footer_reg, footer_next;

    // Check stage
    logic              eval_valid_reg;
    logic [WORD_W-1:0] eval_count_reg;
    logic              eval_magic_reg;
    logic              eval_ver_reg;
    logic [WORD_W-1:0] eval_decl_reg;
    logic [WORD_W-1:0] eval_sum_reg;
    logic [WORD_W-1:0] eval_footer_reg;

    // Output stage
    logic              out_valid_reg;
    status_t           status_reg, status_next;
    logic [WORD_W-1:0] length_reg;

    logic              accept;
    logic              frame_end;
    logic              eval_adv;
    logic [WORD_W-1:0] body_off;

    assign eval_adv  = !out_valid_reg || !out_stall;
    assign in_stall  = eval_valid_reg && !eval_adv;
    assign accept    = in_valid && !in_stall;
    assign frame_end = accept && last_byte;
    assign body_off  = count_reg - HDR_BYTES;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_cfg_reg   <= '0;
            version_cfg_reg <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_MAGIC:   magic_cfg_reg   <= cfg_data;
                REG_VERSION: version_cfg_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        shift_next  = shift_reg;
        magic_next  = magic_reg;
        ver_next    = ver_reg;
        decl_next   = decl_reg;
        sum_next    = sum_reg;
        footer_next = footer_reg;
        // a saturated counter drops the byte
        if (accept && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + 32'd1;
            if (count_reg < HDR_BYTES)
            begin
                shift_next = {data_byte, shift_reg[WORD_W-1:BYTE_W]};
                if (count_reg == MAGIC_END)
                    magic_next = (shift_next == magic_cfg_reg);
                else if (count_reg == VERSION_END)
                    ver_next = (shift_next == version_cfg_reg);
                else if (count_reg == LENGTH_END)
                    decl_next = shift_next;
            end
            else if (body_off < decl_reg)
                sum_next = sum_step(sum_reg, data_byte);
            else if ((body_off - decl_reg) < FOOTER_LEN)
                footer_next = {data_byte, footer_reg[WORD_W-1:BYTE_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            shift_reg  <= '0;
            magic_reg  <= 1'b0;
            ver_reg    <= 1'b0;
            decl_reg   <= '0;
            sum_reg    <= SUM_SEED;
            footer_reg <= '0;
        end
        else if (frame_end)
        begin
            count_reg  <= '0;
            shift_reg  <= '0;
            magic_reg  <= 1'b0;
            ver_reg    <= 1'b0;
            decl_reg   <= '0;
            sum_reg    <= SUM_SEED;
            footer_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            shift_reg  <= shift_next;
            magic_reg  <= magic_next;
            ver_reg    <= ver_next;
            decl_reg   <= decl_next;
            sum_reg    <= sum_next;
            footer_reg <= footer_next;
        end
    end

    // Snapshot the finished frame into the check stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eval_valid_reg <= 1'b0;
        else if (frame_end)
            eval_valid_reg <= 1'b1;
        else if (eval_adv)
            eval_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (frame_end)
        begin
            eval_count_reg  <= count_next;
            eval_magic_reg  <= magic_next;
            eval_ver_reg    <= ver_next;
            eval_decl_reg   <= decl_next;
            eval_sum_reg    <= sum_next;
            eval_footer_reg <= footer_next;
        end
    end

    always_comb
    begin
        if (eval_count_reg < MIN_BYTES)
            status_next = ST_SHORT;
        else if (!eval_magic_reg)
            status_next = ST_BAD_MAGIC;
        else if (!eval_ver_reg)
            status_next = ST_BAD_VER;
        else if (({1'b0, eval_decl_reg} + {1'b0, MIN_BYTES}) > {1'b0, eval_count_reg})
            status_next = ST_BAD_LEN;
        else if (eval_sum_reg != eval_footer_reg)
            status_next = ST_BAD_SUM;
        else
            status_next = ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (eval_valid_reg && eval_adv)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (eval_valid_reg && eval_adv)
        begin
            status_reg <= status_next;
            length_reg <= eval_decl_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign body_length = length_reg;

`ifndef ASSERT_OFF
    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> (count_reg == '0) && (sum_reg == SUM_SEED) && !magic_reg)
        else $error("frame state not cleared after last byte");

    a_frame_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        frame_end |=> eval_valid_reg)
        else $error("finished frame did not reach check stage");

    a_check_held: assert property (@(posedge clk) disable iff (!rst_n)
        (eval_valid_reg && !eval_adv) |=> eval_valid_reg && $stable(eval_decl_reg))
        else $error("waiting frame dropped from check stage");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> eval_valid_reg && out_valid_reg)
        else $error("input stalled with free output space");
`endif

endmodule
